FILE: hw/rtl/multi_token_substring_match_defines.svh
// assertion macros shared by the substring match rtl
`ifndef MULTI_TOKEN_SUBSTRING_MATCH_DEFINES_SVH
`define MULTI_TOKEN_SUBSTRING_MATCH_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define MTSM_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while in reset
`define MTSM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hw/rtl/mtsm_pkg.sv
// package: constants, register codes and helpers of the substring match block
package mtsm_pkg;

	localparam int STORED_CHARS    = 24;
	localparam int FILTER_MAX_DEF  = 24;
	localparam int CFG_DATA_W      = 64;
	localparam int CFG_ADDR_W      = 5;
	localparam int LEN_W           = 5;
	localparam int CHAR_W          = 8;
	localparam int FILT_BITS       = STORED_CHARS * CHAR_W;

	localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
	localparam logic [CHAR_W-1:0] CHAR_UPPER_Z = 8'h5a;
	localparam logic [CHAR_W-1:0] CHAR_SPACE   = 8'h20;
	localparam logic [CHAR_W-1:0] CHAR_NUL     = 8'h00;
	localparam logic [CHAR_W-1:0] CASE_OFFSET  = 8'd32;

	typedef enum logic [1:0] {
		REG_FILT_LOW  = 2'd0,
		REG_FILT_MID  = 2'd1,
		REG_FILT_HIGH = 2'd2,
		REG_FILT_LEN  = 2'd3
	} reg_idx_t;

	// fold upper-case letters to lower case, leave everything else
	function automatic logic [CHAR_W-1:0] fold_case(input logic [CHAR_W-1:0] c);
		logic [CHAR_W-1:0] r;
		r = c;
		if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
			r = c + CASE_OFFSET;
		end
		return r;
	endfunction

endpackage

FILE: hw/rtl/multi_token_substring_match.sv
// top level: case-insensitive multi-token substring match over a byte stream
//
// usage:
//  - the filter (up to 24 characters, split at spaces into tokens) is written over
//    the apb port: filter_bytes_low at 0x00, filter_bytes_mid at 0x08,
//    filter_bytes_high at 0x10, filter_length at 0x18; reads return the registers
//  - haystack bytes enter on the s_ stream, one item per byte; s_tuser flags a real
//    byte, s_tlast marks the final item of the haystack; a zero byte ends the string
//  - each item marked last yields one item on the m_ stream: m_tdata[0] is 1 when
//    some token occurred as a substring, or when the filter holds no token
// timing:
//  - one item per cycle sustained; the shift-and update of the 24-bit prefix vector
//    runs on the item held in the input register
//  - m_tvalid is registered: a last item passes the input, then the result register
//  - the result register lets input keep flowing while a result waits; only a last
//    item meeting a full, stalled result register holds the input side
// reset:
//  - arst_n clears the filter, the match state and both valid flags
`include "multi_token_substring_match_defines.svh"

module multi_token_substring_match #(
	parameter int FILTER_MAX = mtsm_pkg::FILTER_MAX_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// apb configuration port
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [mtsm_pkg::CFG_ADDR_W-1:0] paddr,
	input  logic [mtsm_pkg::CFG_DATA_W-1:0] pwdata,
	output logic [mtsm_pkg::CFG_DATA_W-1:0] prdata,
	output logic                            pready,
	// haystack input stream
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [7:0]                      s_tdata,  // [7:0] hay_byte
	input  logic [0:0]                      s_tuser,  // [0] byte_present
	input  logic                            s_tlast,  // is_last
	// result stream
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [7:0]                      m_tdata   // [0] matched, [7:1] zero
);
	import mtsm_pkg::*;

	// width of the match vector: one bit per usable filter position
	localparam int VEC_W = (FILTER_MAX < STORED_CHARS) ? FILTER_MAX : STORED_CHARS;
	localparam logic [LEN_W-1:0] CAP_LEN = LEN_W'(VEC_W);

	// configuration registers
	logic [CFG_DATA_W-1:0] filt_low_q;
	logic [CFG_DATA_W-1:0] filt_mid_q;
	logic [CFG_DATA_W-1:0] filt_high_q;
	logic [LEN_W-1:0]      filt_len_q;

	reg_idx_t              cfg_idx;
	logic                  cfg_wr;

	// input register
	logic                  in_valid_s1;
	logic [CHAR_W-1:0]     in_byte_s1;
	logic                  in_present_s1;
	logic                  in_last_s1;

	// result register
	logic                  out_valid_s2;
	logic                  out_matched_s2;

	// match state
	logic [VEC_W-1:0]      pv_q;
	logic                  found_q;
	logic                  ended_q;

	// derived filter masks
	logic [FILT_BITS-1:0]  filt_all;
	logic [LEN_W-1:0]      len_sat;
	logic [VEC_W-1:0]      zero_vec;
	logic [VEC_W-1:0]      space_vec;
	logic [VEC_W-1:0]      all_mask;
	logic [VEC_W-1:0]      tok_mask;
	logic [VEC_W-1:0]      start_mask;
	logic [VEC_W-1:0]      end_mask;
	logic [VEC_W-1:0]      eq_mask;
	logic [CHAR_W-1:0]     hay_fold;

	// next state
	logic [VEC_W-1:0]      pv_masked;
	logic [VEC_W-1:0]      pv_next;
	logic                  found_next;
	logic                  ended_next;

	// handshake
	logic                  out_free;
	logic                  s1_fire;

	// ---------------------------------------------------------------
	// configuration port
	// ---------------------------------------------------------------
	assign pready  = 1'b1;
	assign cfg_idx = reg_idx_t'(paddr[CFG_ADDR_W-1:CFG_ADDR_W-2]);
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filt_low_q  <= '0;
			filt_mid_q  <= '0;
			filt_high_q <= '0;
			filt_len_q  <= '0;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_FILT_LOW:  filt_low_q  <= pwdata;
				REG_FILT_MID:  filt_mid_q  <= pwdata;
				REG_FILT_HIGH: filt_high_q <= pwdata;
				REG_FILT_LEN:  filt_len_q  <= pwdata[LEN_W-1:0];
				default:       filt_len_q  <= filt_len_q;
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			REG_FILT_LOW:  prdata = filt_low_q;
			REG_FILT_MID:  prdata = filt_mid_q;
			REG_FILT_HIGH: prdata = filt_high_q;
			REG_FILT_LEN:  prdata = CFG_DATA_W'(filt_len_q);
			default:       prdata = '0;
		endcase
	end

	// ---------------------------------------------------------------
	// filter masks from the registers; eq_mask also compares the input byte
	// ---------------------------------------------------------------
	assign filt_all = {filt_high_q, filt_mid_q, filt_low_q};
	// length saturates at the number of usable positions
	assign len_sat  = (filt_len_q > CAP_LEN) ? CAP_LEN : filt_len_q;
	assign hay_fold = fold_case(in_byte_s1);

	always_comb begin
		for (int i = 0; i < VEC_W; i++) begin
			zero_vec[i]  = (filt_all[CHAR_W*i +: CHAR_W] == CHAR_NUL);
			space_vec[i] = (filt_all[CHAR_W*i +: CHAR_W] == CHAR_SPACE);
			eq_mask[i]   = in_present_s1 &&
				(fold_case(filt_all[CHAR_W*i +: CHAR_W]) == hay_fold);
		end
		// a position is live below the length and before the first zero character
		for (int i = 0; i < VEC_W; i++) begin
			all_mask[i] = (LEN_W'(i) < len_sat) &&
				!(|(zero_vec & ({VEC_W{1'b1}} >> (VEC_W - 1 - i))));
		end
	end

	// token characters, token starts (first position or after a space) and ends
	// (last live position or before a space)
	assign tok_mask   = all_mask & ~space_vec;
	assign start_mask = (space_vec << 1) | VEC_W'(1);
	assign end_mask   = (space_vec >> 1) | (all_mask & ~(all_mask >> 1));

	// ---------------------------------------------------------------
	// handshake
	// ---------------------------------------------------------------
	// a non-last item never needs the result register
	assign out_free = !out_valid_s2 || m_tready;
	assign s1_fire  = in_valid_s1 && (!in_last_s1 || out_free);
	assign s_tready = !in_valid_s1 || s1_fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (s_tready) begin
			in_valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			in_byte_s1    <= s_tdata;
			in_present_s1 <= s_tuser[0];
			in_last_s1    <= s_tlast;
		end
	end

	// ---------------------------------------------------------------
	// shift-and update
	// ---------------------------------------------------------------
	always_comb begin
		// vector follows the current filter length
		pv_masked  = pv_q & all_mask;
		pv_next    = pv_masked;
		found_next = found_q;
		ended_next = ended_q;
		if (in_present_s1 && !ended_q) begin
			if (in_byte_s1 == CHAR_NUL) begin
				ended_next = 1'b1;
			end else begin
				pv_next    = ((pv_masked << 1) | start_mask) & eq_mask & tok_mask;
				found_next = found_q || (|(pv_next & end_mask));
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pv_q    <= '0;
			found_q <= 1'b0;
			ended_q <= 1'b0;
		end else if (s1_fire) begin
			if (in_last_s1) begin
				// end of haystack: start the next one clean
				pv_q    <= '0;
				found_q <= 1'b0;
				ended_q <= 1'b0;
			end else begin
				pv_q    <= pv_next;
				found_q <= found_next;
				ended_q <= ended_next;
			end
		end
	end

	// ---------------------------------------------------------------
	// result register
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (s1_fire && in_last_s1) begin
			out_valid_s2 <= 1'b1;
		end else if (m_tready) begin
			out_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire && in_last_s1) begin
			// an all-space or empty filter has no token and matches everything
			out_matched_s2 <= found_next || (tok_mask == '0);
		end
	end

	assign m_tvalid = out_valid_s2;
	assign m_tdata  = {7'b0, out_matched_s2};

	// ---------------------------------------------------------------
	// assertions
	// ---------------------------------------------------------------
	`MTSM_ASSERT_NEXT(a_clear_after_last, s1_fire && in_last_s1,
		out_valid_s2 && !found_q && !ended_q && (pv_q == '0),
		"state not cleared or result missing after last item")
	`MTSM_ASSERT_NEXT(a_ended_sticky, ended_q && !(s1_fire && in_last_s1), ended_q,
		"string end flag dropped before the last item")
	`MTSM_ASSERT_NEXT(a_last_held, in_valid_s1 && in_last_s1 && !out_free,
		in_valid_s1 && in_last_s1, "blocked last item lost from input register")
	`MTSM_ASSERT_NEXT(a_empty_matches, s1_fire && in_last_s1 && (tok_mask == '0),
		out_matched_s2, "filter without tokens did not match")
	`MTSM_ASSERT_NOW(a_no_accept_when_blocked, in_valid_s1 && !s1_fire, !s_tready,
		"input accepted while input register holds a stalled item")

endmodule
